// ===== rtl/core/bpfa_pkg.sv =====
// Shared types and constants for the bitmap page frame allocator.
package bpfa_pkg;

  // Bitmap word geometry: one RAM row holds WORD_W frame bits.
  localparam int unsigned WORD_W = 16;
  localparam int unsigned BIT_W  = 4;

  localparam int unsigned DEF_MAX_PAGES = 32;
  localparam int unsigned RESET_PAGES   = 32;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned PAGE_W   = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_TEST  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CHK
  } state_e;

endpackage

// ===== rtl/core/bitmap_page_frame_allocator_core.sv =====
// Top level of the bitmap first-fit page frame allocator.
// The used-frame bitmap lives in a RAM of 16-bit words with one bit per frame, and a
// per-word valid flag makes a word that was never written since reset or since the
// last limit write read as all free, so neither needs a clearing pass. Commands arrive
// as words on a valid/ready channel: 0 allocates the lowest free frame below the
// limit, 1 frees a frame, 2 tests a frame, 3 does nothing; every result word carries
// the free count after the command. A test or free steps through accept, RAM read, and
// check and write back. An allocate accepts, then reads and checks one bitmap word
// after another until one holds a free frame or none is left below the limit. The
// result goes to an output register, so the next command is taken while a result
// still waits. Writing cfg_data_i (frame count, saturated to MAX_PAGES) restarts the
// allocator: all frames free and the count set to the new limit.
module bitmap_page_frame_allocator_core #(
  parameter int unsigned MAX_PAGES = bpfa_pkg::DEF_MAX_PAGES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bpfa_pkg::COUNT_W-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bpfa_pkg::CMD_W-1:0]     cmd_i,
  input  logic [bpfa_pkg::PAGE_W-1:0]    page_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bpfa_pkg::STATUS_W-1:0]  status_o,
  output logic [bpfa_pkg::PAGE_W-1:0]    page_out_o,
  output logic                           allocated_o,
  output logic [bpfa_pkg::COUNT_W-1:0]   free_count_o
);

  import bpfa_pkg::*;

  localparam int unsigned NUM_WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned PIDX_W    = WADDR_W + BIT_W;
  localparam int unsigned CMP_W     = ((PIDX_W > COUNT_W) ? PIDX_W : COUNT_W) + 1;
  localparam int unsigned RST_LIM   = (RESET_PAGES > MAX_PAGES) ? MAX_PAGES : RESET_PAGES;

  // State registers
  state_e               state_q, state_d;
  logic [CMD_W-1:0]     cmd_q;
  logic [PAGE_W-1:0]    page_q;
  logic [WADDR_W-1:0]   widx_q, widx_d;
  logic [COUNT_W-1:0]   limit_q, limit_d;
  logic [COUNT_W-1:0]   free_q, free_d;
  logic [NUM_WORDS-1:0] vld_q, vld_d;

  // Result register
  logic                 out_valid_q;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [PAGE_W-1:0]    page_out_q, page_out_d;
  logic                 allocated_q, allocated_d;
  logic                 out_load;

  // RAM port
  logic                 ram_we, ram_re;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata;

  // Word evaluation
  logic [WORD_W-1:0]    word, cand, lane_ok;
  logic                 hit;
  logic [BIT_W-1:0]     hit_bit;
  logic [BIT_W-1:0]     bit_sel;
  logic                 page_used, in_range, more, out_free;
  logic [CMP_W-1:0]     limit_ext, next_base;
  logic [COUNT_W-1:0]   cfg_lim;

  bpfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS),
    .AW    (WADDR_W)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (widx_q),
    .rdata_o (ram_rdata)
  );

  // Saturate the written frame count to the bitmap size.
  assign cfg_lim = ({{(32-COUNT_W){1'b0}}, cfg_data_i} > MAX_PAGES) ?
                   COUNT_W'(MAX_PAGES) : cfg_data_i;

  // A row not written since the last restart reads as all free.
  assign word      = vld_q[widx_q] ? ram_rdata : '0;
  assign limit_ext = CMP_W'(limit_q);
  assign bit_sel   = page_q[BIT_W-1:0];
  assign page_used = word[bit_sel];
  assign in_range  = {1'b0, page_q} < limit_q;
  assign next_base = CMP_W'({widx_q, {BIT_W{1'b0}}}) + CMP_W'(WORD_W);
  assign more      = (next_base < limit_ext) && (widx_q != WADDR_W'(NUM_WORDS - 1));
  assign out_free  = !out_valid_q || out_ready_i;

  // Frames of this word that lie below the limit
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      lane_ok[b] = CMP_W'({widx_q, BIT_W'(b)}) < limit_ext;
    end
  end

  assign cand = ~word & lane_ok;

  // Lowest free frame in the word
  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit     = 1'b1;
        hit_bit = BIT_W'(b);
      end
    end
  end

  // Sequencer: accept, read one bitmap word, check and write back.
  // A write back happens in S_CHK and the next read of the same row only in a
  // later S_RD, after S_IDLE, so no forwarding path is needed.
  always_comb begin
    state_d     = state_q;
    widx_d      = widx_q;
    limit_d     = limit_q;
    free_d      = free_q;
    vld_d       = vld_q;
    in_ready_o  = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = word;
    out_load    = 1'b0;
    status_d    = ST_OK;
    page_out_d  = '0;
    allocated_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          widx_d  = (cmd_i == CMD_ALLOC) ? '0 : WADDR_W'(page_i >> BIT_W);
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (cmd_q == CMD_ALLOC) begin
          ram_re = (limit_q != '0);
        end else if (cmd_q == CMD_FREE || cmd_q == CMD_TEST) begin
          ram_re = in_range;
        end
        state_d = S_CHK;
      end
      S_CHK: begin
        if (cmd_q == CMD_ALLOC) begin
          if (limit_q != '0 && !hit && more) begin
            // nothing free here, scan the next word
            widx_d  = widx_q + 1'b1;
            state_d = S_RD;
          end else if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
            if (limit_q != '0 && hit) begin
              page_out_d     = PAGE_W'({widx_q, hit_bit});
              ram_we         = 1'b1;
              ram_wdata      = word | (WORD_W'(1) << hit_bit);
              vld_d[widx_q]  = 1'b1;
              free_d         = free_q - 1'b1;
            end else begin
              status_d = ST_NONE;
            end
          end
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (cmd_q == CMD_FREE || cmd_q == CMD_TEST) begin
            if (!in_range) begin
              status_d = ST_RANGE;
            end else begin
              allocated_d = page_used;
              if (cmd_q == CMD_FREE && page_used) begin
                ram_we        = 1'b1;
                ram_wdata     = word & ~(WORD_W'(1) << bit_sel);
                vld_d[widx_q] = 1'b1;
                free_d        = free_q + 1'b1;
              end
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Limit write restarts the allocator; user to issue it only when idle, unchecked.
    if (cfg_we_i) begin
      limit_d = cfg_lim;
      free_d  = cfg_lim;
      vld_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      widx_q      <= '0;
      limit_q     <= COUNT_W'(RST_LIM);
      free_q      <= COUNT_W'(RST_LIM);
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      widx_q  <= widx_d;
      limit_q <= limit_d;
      free_q  <= free_d;
      vld_q   <= vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Command and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= cmd_i;
      page_q <= page_i;
    end
    if (out_load) begin
      status_q    <= status_d;
      page_out_q  <= page_out_d;
      allocated_q <= allocated_d;
    end
  end

  // Save for a limit write, free_q moves only as a result loads, and so matches it.
  logic [COUNT_W-1:0] free_out_q;
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      free_out_q <= free_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign page_out_o   = page_out_q;
  assign allocated_o  = allocated_q;
  assign free_count_o = free_out_q;

endmodule

// ===== rtl/core/bpfa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bpfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the bitmap page frame allocator core.
module tb_top;
  import bpfa_pkg::*;

  // Command code 3 has no package name; the core treats it as a no-op.
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  // Cycles with no handshake on either channel before the run is declared hung.
  // The slowest legit gap is a full allocate scan behind a long receiver stall,
  // so this is many times what a correct core needs.
  localparam int STALL_LIMIT = 2000;

  // Random part: segments of words, each under its own frame limit.
  localparam int SEGMENTS  = 16;
  localparam int SEG_WORDS = 100;

  typedef struct packed {
    status_e              status;
    logic [PAGE_W-1:0]    page_out;
    logic                 allocated;
    logic [COUNT_W-1:0]   free_count;
  } frame_result_t;

  // One row of the directed table: either a limit write or a command word.
  // typed rows carry a hand-written result, the others take the prediction.
  typedef struct packed {
    logic                 is_cfg;
    logic [COUNT_W-1:0]   cfg_val;
    logic [CMD_W-1:0]     cmd;
    logic [PAGE_W-1:0]    page;
    logic                 typed;
    frame_result_t        res;
  } stim_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [COUNT_W-1:0]   cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [CMD_W-1:0]     cmd_i       = '0;
  logic [PAGE_W-1:0]    page_i      = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [PAGE_W-1:0]    page_out_o;
  logic                 allocated_o;
  logic [COUNT_W-1:0]   free_count_o;

  // Predictor state: the limit register, the used-frame map and the free count.
  logic [COUNT_W-1:0]         limit_cfg;
  logic [DEF_MAX_PAGES-1:0]   frame_used;
  logic [COUNT_W-1:0]         free_cnt;

  frame_result_t  pending[$];     // results owed by the core, oldest first
  stim_row_t      dir_rows[$];
  int             mismatch_cnt = 0;
  int             stall_cycles = 0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;

  bitmap_page_frame_allocator_core #(
    .MAX_PAGES (DEF_MAX_PAGES)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .page_i       (page_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .page_out_o   (page_out_o),
    .allocated_o  (allocated_o),
    .free_count_o (free_count_o)
  );

  // 12-unit clock period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Managed frame count: the register value saturated to the bitmap size.
  function automatic int unsigned frame_limit();
    return (limit_cfg > DEF_MAX_PAGES) ? DEF_MAX_PAGES : int'(limit_cfg);
  endfunction

  // Applies one command word to the predictor state and returns its result.
  function automatic frame_result_t apply_frame_cmd(input logic [CMD_W-1:0] cmd,
                                                    input logic [PAGE_W-1:0] page);
    frame_result_t  r;
    int unsigned    lim;
    int unsigned    f;
    logic           found;
    r.status     = ST_OK;
    r.page_out   = '0;
    r.allocated  = 1'b0;
    lim          = frame_limit();
    found        = 1'b0;
    case (cmd)
      CMD_ALLOC: begin
        // first fit: lowest clear bit below the limit
        r.status = ST_NONE;
        for (f = 0; f < lim && !found; f++) begin
          if (!frame_used[f]) begin
            frame_used[f] = 1'b1;
            free_cnt      = free_cnt - 1'b1;
            r.page_out    = f[PAGE_W-1:0];
            r.status      = ST_OK;
            found         = 1'b1;
          end
        end
      end
      CMD_FREE, CMD_TEST: begin
        if (page >= lim) begin
          r.status = ST_RANGE;
        end else begin
          r.allocated = frame_used[page];
          if (cmd == CMD_FREE && r.allocated) begin
            frame_used[page] = 1'b0;
            free_cnt         = free_cnt + 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.free_count = free_cnt;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [COUNT_W-1:0] v);
    stim_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    return row;
  endfunction

  function automatic stim_row_t cmd_row(input logic [CMD_W-1:0] c, input logic [PAGE_W-1:0] p,
                                        input logic typed, input status_e st,
                                        input logic [PAGE_W-1:0] po, input logic al,
                                        input logic [COUNT_W-1:0] fc);
    stim_row_t row;
    row                = '0;
    row.cmd            = c;
    row.page           = p;
    row.typed          = typed;
    row.res.status     = st;
    row.res.page_out   = po;
    row.res.allocated  = al;
    row.res.free_count = fc;
    return row;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 60)
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
  endtask

  // Presents one command word and holds it until the core takes it. The word is
  // accepted at the rising edge after a falling edge that sees ready high, since
  // all inputs change only at rising edges.
  task automatic send_word(input logic [CMD_W-1:0] c, input logic [PAGE_W-1:0] p,
                           input logic use_typed, input frame_result_t typed_res);
    frame_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    page_i     <= p;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    pred = apply_frame_cmd(c, p);
    pending.push_back(use_typed ? typed_res : pred);
  endtask

  // Returns at a rising edge once every owed result has been taken and the
  // output is empty. Callers lower valid first.
  task automatic wait_drained();
    do @(negedge clk_i); while (pending.size() != 0 || out_valid_o);
    @(posedge clk_i);
  endtask

  // Limit write: one cycle of write enable while the core is idle. It restarts
  // the allocator, so the predictor rebuilds its map and count the same way.
  task automatic write_limit(input logic [COUNT_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    limit_cfg  = v;
    frame_used = '0;
    free_cnt   = COUNT_W'(frame_limit());
  endtask

  // Receiver side: ready is redrawn every cycle from the current idle rate.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result checker and hang watchdog. Sampled mid-cycle, where every signal
  // is stable until the edge that completes the handshake.
  always @(negedge clk_i) begin
    frame_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending.size() == 0) begin
          report_mismatch("result word with nothing owed, status", 8'd0, 8'(status_o));
        end else begin
          want = pending.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", 8'(want.status), 8'(status_o));
          if (page_out_o !== want.page_out)
            report_mismatch("page_out", 8'(want.page_out), 8'(page_out_o));
          if (allocated_o !== want.allocated)
            report_mismatch("allocated", 8'(want.allocated), 8'(allocated_o));
          if (free_count_o !== want.free_count)
            report_mismatch("free_count", 8'(want.free_count), 8'(free_count_o));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles, %0d results owed",
                   stall_cycles, pending.size());
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    stim_row_t            row;
    int                   seg;
    int                   n;
    int unsigned          r;
    int unsigned          lim;
    int                   alloc_pct;
    logic [CMD_W-1:0]     c;
    logic [PAGE_W-1:0]    p;
    logic [COUNT_W-1:0]   lim_val;

    // Predictor starts from the reset state: 32 frames, all free.
    limit_cfg  = COUNT_W'(RESET_PAGES);
    frame_used = '0;
    free_cnt   = COUNT_W'(RESET_PAGES);

    // Directed table. Typed rows are the ones readable at a glance.
    // Fresh allocator, 32 frames.
    dir_rows.push_back(cmd_row(CMD_TEST,  5'd0,  1'b1, ST_OK,    5'd0, 1'b0, 6'd32));
    dir_rows.push_back(cmd_row(CMD_FREE,  5'd31, 1'b1, ST_OK,    5'd0, 1'b0, 6'd32)); // free of a free frame
    dir_rows.push_back(cmd_row(CMD_ALLOC, 5'd0,  1'b1, ST_OK,    5'd0, 1'b0, 6'd31));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 5'd0,  1'b1, ST_OK,    5'd1, 1'b0, 6'd30));
    dir_rows.push_back(cmd_row(CMD_TEST,  5'd1,  1'b1, ST_OK,    5'd0, 1'b1, 6'd30));
    dir_rows.push_back(cmd_row(CMD_FREE,  5'd0,  1'b1, ST_OK,    5'd0, 1'b1, 6'd31));
    dir_rows.push_back(cmd_row(CMD_FREE,  5'd0,  1'b1, ST_OK,    5'd0, 1'b0, 6'd31)); // double free
    dir_rows.push_back(cmd_row(CMD_ALLOC, 5'd31, 1'b0, ST_OK,    5'd0, 1'b0, 6'd0));  // page ignored
    dir_rows.push_back(cmd_row(CMD_NOP,   5'd31, 1'b1, ST_OK,    5'd0, 1'b0, 6'd30));
    dir_rows.push_back(cmd_row(CMD_TEST,  5'd31, 1'b0, ST_OK,    5'd0, 1'b0, 6'd0));
    // One frame: exhaust it, then hit the range check.
    dir_rows.push_back(cfg_row(6'd1));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 5'd0,  1'b1, ST_OK,    5'd0, 1'b0, 6'd0));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 5'd0,  1'b1, ST_NONE,  5'd0, 1'b0, 6'd0));
    dir_rows.push_back(cmd_row(CMD_TEST,  5'd1,  1'b1, ST_RANGE, 5'd0, 1'b0, 6'd0));
    dir_rows.push_back(cmd_row(CMD_FREE,  5'd0,  1'b1, ST_OK,    5'd0, 1'b1, 6'd1));
    // No frames managed at all.
    dir_rows.push_back(cfg_row(6'd0));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 5'd0,  1'b1, ST_NONE,  5'd0, 1'b0, 6'd0));
    dir_rows.push_back(cmd_row(CMD_FREE,  5'd0,  1'b1, ST_RANGE, 5'd0, 1'b0, 6'd0));
    dir_rows.push_back(cmd_row(CMD_TEST,  5'd31, 1'b1, ST_RANGE, 5'd0, 1'b0, 6'd0));
    // Largest register value, saturates to the bitmap size.
    dir_rows.push_back(cfg_row(6'd63));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 5'd0,  1'b1, ST_OK,    5'd0, 1'b0, 6'd31));
    dir_rows.push_back(cmd_row(CMD_TEST,  5'd31, 1'b1, ST_OK,    5'd0, 1'b0, 6'd31));
    dir_rows.push_back(cmd_row(CMD_FREE,  5'd31, 1'b0, ST_OK,    5'd0, 1'b0, 6'd0));
    dir_rows.push_back(cmd_row(CMD_NOP,   5'd0,  1'b1, ST_OK,    5'd0, 1'b0, 6'd31));
    // Two frames: fill, overflow, give one back.
    dir_rows.push_back(cfg_row(6'd2));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 5'd0,  1'b1, ST_OK,    5'd0, 1'b0, 6'd1));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 5'd0,  1'b1, ST_OK,    5'd1, 1'b0, 6'd0));
    dir_rows.push_back(cmd_row(CMD_ALLOC, 5'd0,  1'b1, ST_NONE,  5'd0, 1'b0, 6'd0));
    dir_rows.push_back(cmd_row(CMD_FREE,  5'd1,  1'b1, ST_OK,    5'd0, 1'b1, 6'd1));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part runs with a slow-ish sender and a busy receiver.
    send_idle_pct = 26;
    recv_idle_pct = 69;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        in_valid_i <= 1'b0;
        wait_drained();
        write_limit(row.cfg_val);
      end else begin
        send_word(row.cmd, row.page, row.typed, row.res);
      end
    end

    // Random part. Each segment picks a limit; alloc-heavy and free-heavy
    // stretches alternate so the map swings between full and empty.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 6) begin
        send_idle_pct = 26;
        recv_idle_pct = 69;
      end else if (seg < 11) begin
        send_idle_pct = 69;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0:       lim_val = 6'd63;
        1:       lim_val = 6'd0;
        2:       lim_val = 6'd1;
        3:       lim_val = 6'd32;
        default: begin
          r = $urandom_range(0, 9);
          if (r < 5)      lim_val = COUNT_W'($urandom_range(1, 8));
          else if (r < 8) lim_val = COUNT_W'($urandom_range(9, 32));
          else            lim_val = COUNT_W'($urandom_range(33, 63));
        end
      endcase
      in_valid_i <= 1'b0;
      wait_drained();
      write_limit(lim_val);

      for (n = 0; n < SEG_WORDS; n++) begin
        // Occasionally hold off until the core has answered everything.
        if ((seg == 4 && n == 50) || $urandom_range(0, 99) == 0) begin
          in_valid_i <= 1'b0;
          wait_drained();
        end
        alloc_pct = ((n / 25) % 2) ? 75 : 25;
        r = $urandom_range(0, 99);
        if (r < alloc_pct)
          c = CMD_ALLOC;
        else if (r < alloc_pct + 3)
          c = CMD_NOP;
        else if (r < alloc_pct + 3 + (97 - alloc_pct) * 6 / 10)
          c = CMD_FREE;
        else
          c = CMD_TEST;
        // Mostly pages inside the limit so free and test hit real frames.
        lim = frame_limit();
        if (lim != 0 && $urandom_range(0, 99) < 85)
          p = PAGE_W'($urandom_range(0, lim - 1));
        else
          p = PAGE_W'($urandom_range(0, 31));
        send_word(c, p, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    // Keep clocking to catch any stray result word.
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bpfa_pkg.sv
rtl/core/bpfa_ram.sv
rtl/core/bitmap_page_frame_allocator_core.sv
sim/tb_top.sv
